// File: rtl/core/vlm_pkg.sv
// Shared types and constants of the voice level meter.
`default_nettype none

package vlm_pkg;

   // Field and register widths.
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 15;
   localparam int RATE_W   = 16;
   localparam int DIVR_W   = 10;
   localparam int SUM_W    = 40;
   localparam int FILT_W   = 32;
   localparam int FLOOR_W  = 32;
   localparam int ENV_W    = 16;
   localparam int LEVEL_W  = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_HP_COEF      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FLOOR_OFFSET = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL_DIV    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FLOOR_FALL   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FLOOR_RISE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ENV_ATTACK   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ENV_RELEASE  = 3'd6;

   // Reset values of the registers.
   localparam logic [COEF_W-1:0]    RST_HP_COEF      = 15'd31130;
   localparam logic [15:0]          RST_FLOOR_OFFSET = 16'd90;
   localparam logic [DIVR_W-1:0]    RST_LEVEL_DIV    = 10'd30;
   localparam logic [RATE_W-1:0]    RST_FLOOR_FALL   = 16'd3277;
   localparam logic [RATE_W-1:0]    RST_FLOOR_RISE   = 16'd33;
   localparam logic [RATE_W-1:0]    RST_ENV_ATTACK   = 16'd45875;
   localparam logic [RATE_W-1:0]    RST_ENV_RELEASE  = 16'd36045;

   // Largest target level, 255.0 in 8.8.
   localparam logic [ENV_W-1:0] TARGET_MAX = 16'd65280;

   // Operand selection of the shared multiplier.
   typedef enum logic [1:0] {
      MUL_FILT  = 2'd0,
      MUL_FLOOR = 2'd1,
      MUL_ENV   = 2'd2
   } mul_sel_type;

   // Controller states, one-hot.
   typedef enum logic [10:0] {
      ST_IDLE      = 11'b000_0000_0001,
      ST_MUL       = 11'b000_0000_0010,
      ST_ACC       = 11'b000_0000_0100,
      ST_DIVM_GO   = 11'b000_0000_1000,
      ST_DIVM_WAIT = 11'b000_0001_0000,
      ST_FLR_MUL   = 11'b000_0010_0000,
      ST_FLR_UPD   = 11'b000_0100_0000,
      ST_DIVL_GO   = 11'b000_1000_0000,
      ST_DIVL_WAIT = 11'b001_0000_0000,
      ST_ENV_MUL   = 11'b010_0000_0000,
      ST_ENV_UPD   = 11'b100_0000_0000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        capture;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        filt_upd;
      logic        div_start;
      logic        div_level;
      logic        mean_load;
      logic        floor_upd;
      logic        target_load;
      logic        env_upd;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last;
      logic div_busy;
      logic out_full;
   } sts_type;

endpackage

`default_nettype wire

// File: rtl/core/voice_level_meter.sv
// Top level of the voice level meter: controller and datapath.
//
//   Channel   Ports                                  Direction  Carries
//   req       req_valid/ready, req_sample/block_end  in         one microphone sample
//   rsp       rsp_valid/ready, rsp_level             out        level of a finished block
//   csr       csr_we, csr_index, csr_wdata           in         register writes, no read-back
//
// A sample without block_end is accepted, multiplied and then used for the filter update.
// The last sample of a block also passes twice through the shared one-bit-per-cycle
// 40-step divider (mean, then level), followed by the floor and the envelope multiply
// steps respectively. Reset is synchronous and needs no clearing pass.
// A level waiting on rsp does not block new samples; only the next block end
// waits until that level has been taken.
`default_nettype none

module voice_level_meter #(
   parameter int MAX_BLOCK = 256
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [vlm_pkg::SAMPLE_W-1:0]  req_sample,
   input  wire logic                                 req_block_end,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic             [vlm_pkg::LEVEL_W-1:0]   rsp_level,
   input  wire logic                                 csr_we,
   input  wire logic        [vlm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic        [vlm_pkg::CSR_DAT_W-1:0] csr_wdata
);

   vlm_pkg::cmd_type cmd;
   vlm_pkg::sts_type sts;

   vlm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   vlm_datapath #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_sample    (req_sample),
      .req_block_end (req_block_end),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_level     (rsp_level),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

endmodule

`default_nettype wire

// File: rtl/core/vlm_divider.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module vlm_divider #(
   parameter int DVD_W = 40,
   parameter int DVS_W = 10
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  busy,
   output logic      [DVD_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic              busy_ff;
   logic [STEP_W-1:0] step_ff;
   logic [DVS_W-1:0]  rem_ff;
   logic [DVD_W-1:0]  quo_ff;
   logic [DVS_W-1:0]  dvs_ff;

   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    trial_diff;
   logic              fits;
   logic [DVS_W-1:0]  rem_in;
   logic [DVD_W-1:0]  quo_in;

   // The remainder stays below the divisor, so the trial value needs one extra bit.
   assign trial      = {rem_ff, quo_ff[DVD_W-1]};
   assign trial_diff = trial - {1'b0, dvs_ff};
   assign fits       = trial >= {1'b0, dvs_ff};
   assign rem_in     = fits ? trial_diff[DVS_W-1:0] : trial[DVS_W-1:0];
   assign quo_in     = {quo_ff[DVD_W-2:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= STEP_W'(DVD_W);
      end else if (busy_ff) begin
         step_ff <= step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: rtl/core/vlm_datapath.sv
// Datapath of the voice level meter: filter, block sum, floor, envelope and output register.
`default_nettype none

module vlm_datapath #(
   parameter int MAX_BLOCK = 256
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire vlm_pkg::cmd_type                    cmd,
   output vlm_pkg::sts_type                         sts,
   input  wire logic signed [vlm_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic                                req_block_end,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic             [vlm_pkg::LEVEL_W-1:0]  rsp_level,
   input  wire logic                                csr_we,
   input  wire logic        [vlm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic        [vlm_pkg::CSR_DAT_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_BLOCK + 1);
   localparam int DVS_W = (CNT_W > vlm_pkg::DIVR_W) ? CNT_W : vlm_pkg::DIVR_W;

   // Configuration registers.
   logic [vlm_pkg::COEF_W-1:0] hp_coef_ff;
   logic [15:0]                floor_offset_ff;
   logic [vlm_pkg::DIVR_W-1:0] level_div_ff;
   logic [vlm_pkg::RATE_W-1:0] floor_fall_ff;
   logic [vlm_pkg::RATE_W-1:0] floor_rise_ff;
   logic [vlm_pkg::RATE_W-1:0] env_attack_ff;
   logic [vlm_pkg::RATE_W-1:0] env_release_ff;

   // Request and running state.
   logic signed [vlm_pkg::SAMPLE_W-1:0] sample_ff;
   logic                                last_ff;
   logic signed [vlm_pkg::SAMPLE_W-1:0] prev_ff;
   logic signed [vlm_pkg::FILT_W-1:0]   filt_ff;
   logic        [vlm_pkg::SUM_W-1:0]    sum_ff;
   logic        [CNT_W-1:0]             count_ff;
   logic        [vlm_pkg::FLOOR_W-1:0]  floor_ff;
   logic                                known_ff;
   logic        [vlm_pkg::ENV_W-1:0]    env_ff;
   logic        [31:0]                  mean_ff;
   logic        [vlm_pkg::ENV_W-1:0]    target_ff;
   logic signed [50:0]                  prod_ff;
   logic        [vlm_pkg::LEVEL_W-1:0]  level_ff;
   logic                                rsp_valid_ff;

   // Shared multiplier.
   logic signed [33:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [50:0] prod_in;
   logic signed [50:0] rnd15;
   logic signed [50:0] rnd16;

   // Filter and block sum.
   logic signed [16:0]                 in_diff;
   logic signed [51:0]                 filt_sum;
   logic signed [vlm_pkg::FILT_W-1:0]  filt_in;
   logic        [31:0]                 mag;
   logic        [vlm_pkg::SUM_W:0]     sum_add;
   logic        [vlm_pkg::SUM_W-1:0]   sum_in;
   logic                               count_room;

   // Noise floor.
   logic        [vlm_pkg::FLOOR_W-1:0] floor_base;
   logic signed [33:0]                 floor_delta;
   logic        [vlm_pkg::RATE_W-1:0]  floor_rate;
   logic signed [51:0]                 floor_sum;
   logic        [vlm_pkg::FLOOR_W-1:0] floor_in;

   // Level division.
   logic signed [34:0]                 excess;
   logic        [vlm_pkg::SUM_W-1:0]   level_dividend;
   logic        [vlm_pkg::SUM_W-1:0]   div_dividend;
   logic        [DVS_W-1:0]            div_divisor;
   logic                               div_busy;
   logic        [vlm_pkg::SUM_W-1:0]   quotient;
   logic        [vlm_pkg::ENV_W-1:0]   target_in;

   // Envelope and level.
   logic signed [16:0]                 env_delta;
   logic        [vlm_pkg::RATE_W-1:0]  env_rate;
   logic signed [51:0]                 env_sum;
   logic        [vlm_pkg::ENV_W-1:0]   env_in;
   logic        [16:0]                 level_sum;
   logic        [vlm_pkg::LEVEL_W-1:0] level_in;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         hp_coef_ff      <= vlm_pkg::RST_HP_COEF;
         floor_offset_ff <= vlm_pkg::RST_FLOOR_OFFSET;
         level_div_ff    <= vlm_pkg::RST_LEVEL_DIV;
         floor_fall_ff   <= vlm_pkg::RST_FLOOR_FALL;
         floor_rise_ff   <= vlm_pkg::RST_FLOOR_RISE;
         env_attack_ff   <= vlm_pkg::RST_ENV_ATTACK;
         env_release_ff  <= vlm_pkg::RST_ENV_RELEASE;
      end else if (csr_we) begin
         unique case (csr_index)
            vlm_pkg::REG_HP_COEF:      hp_coef_ff      <= csr_wdata[vlm_pkg::COEF_W-1:0];
            vlm_pkg::REG_FLOOR_OFFSET: floor_offset_ff <= csr_wdata;
            vlm_pkg::REG_LEVEL_DIV:    level_div_ff    <= csr_wdata[vlm_pkg::DIVR_W-1:0];
            vlm_pkg::REG_FLOOR_FALL:   floor_fall_ff   <= csr_wdata;
            vlm_pkg::REG_FLOOR_RISE:   floor_rise_ff   <= csr_wdata;
            vlm_pkg::REG_ENV_ATTACK:   env_attack_ff   <= csr_wdata;
            vlm_pkg::REG_ENV_RELEASE:  env_release_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------ multiplier
   assign floor_base  = known_ff ? floor_ff : mean_ff;
   assign floor_delta = $signed({2'b00, mean_ff}) - $signed({2'b00, floor_base});
   assign floor_rate  = (mean_ff < floor_base) ? floor_fall_ff : floor_rise_ff;

   assign env_delta = $signed({1'b0, target_ff}) - $signed({1'b0, env_ff});
   assign env_rate  = (target_ff > env_ff) ? env_attack_ff : env_release_ff;

   always_comb begin
      case (cmd.mul_sel)
         vlm_pkg::MUL_FILT: begin
            mul_a = {{2{filt_ff[vlm_pkg::FILT_W-1]}}, filt_ff};
            mul_b = {2'b00, hp_coef_ff};
         end
         vlm_pkg::MUL_FLOOR: begin
            mul_a = floor_delta;
            mul_b = {1'b0, floor_rate};
         end
         vlm_pkg::MUL_ENV: begin
            mul_a = {{17{env_delta[16]}}, env_delta};
            mul_b = {1'b0, env_rate};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Round to nearest with ties upward, then drop the fraction bits.
   assign rnd15 = (prod_ff + 51'sd16384) >>> 15;
   assign rnd16 = (prod_ff + 51'sd32768) >>> 16;

   // ---------------------------------------------------------------- filter
   assign in_diff  = $signed({sample_ff[15], sample_ff}) - $signed({prev_ff[15], prev_ff});
   assign filt_sum = $signed({{27{in_diff[16]}}, in_diff, 8'd0}) + $signed({rnd15[50], rnd15});

   always_comb begin
      if (filt_sum > 52'sh0_0000_7FFF_FFFF) begin
         filt_in = 32'sh7FFF_FFFF;
      end else if (filt_sum < -52'sh0_0000_8000_0000) begin
         filt_in = 32'sh8000_0000;
      end else begin
         filt_in = filt_sum[31:0];
      end
   end

   assign mag        = filt_in[31] ? (~filt_in + 32'd1) : filt_in;
   assign sum_add    = {1'b0, sum_ff} + {9'd0, mag};
   assign sum_in     = sum_add[vlm_pkg::SUM_W] ? '1 : sum_add[vlm_pkg::SUM_W-1:0];
   assign count_room = count_ff < CNT_W'(MAX_BLOCK);

   // ----------------------------------------------------------- noise floor
   assign floor_sum = $signed({20'd0, floor_ff}) + $signed({rnd16[50], rnd16});

   always_comb begin
      if (floor_sum < 52'sd0) begin
         floor_in = '0;
      end else if (floor_sum > 52'sh0_0000_FFFF_FFFF) begin
         floor_in = '1;
      end else begin
         floor_in = floor_sum[31:0];
      end
   end

   // ---------------------------------------------------------------- divide
   assign excess = $signed({3'b000, mean_ff}) - $signed({3'b000, floor_ff})
                   - $signed({11'd0, floor_offset_ff, 8'd0});
   assign level_dividend = (excess > 35'sd0) ? {6'd0, excess[33:0]} : '0;

   always_comb begin
      if (cmd.div_level) begin
         div_dividend = level_dividend;
         div_divisor  = (level_div_ff == '0) ? DVS_W'(1) : DVS_W'(level_div_ff);
      end else begin
         div_dividend = sum_ff;
         div_divisor  = (count_ff == '0) ? DVS_W'(1) : DVS_W'(count_ff);
      end
   end

   vlm_divider #(
      .DVD_W (vlm_pkg::SUM_W),
      .DVS_W (DVS_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign target_in = (quotient > 40'd65280) ? vlm_pkg::TARGET_MAX
                                             : quotient[vlm_pkg::ENV_W-1:0];

   // -------------------------------------------------------------- envelope
   assign env_sum = $signed({36'd0, env_ff}) + $signed({rnd16[50], rnd16});

   always_comb begin
      if (env_sum < 52'sd0) begin
         env_in = '0;
      end else if (env_sum > 52'sd65535) begin
         env_in = '1;
      end else begin
         env_in = env_sum[15:0];
      end
   end

   assign level_sum = {1'b0, env_in} + 17'd128;
   assign level_in  = level_sum[16] ? 8'hFF : level_sum[15:8];

   // ------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         filt_ff      <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         floor_ff     <= '0;
         known_ff     <= 1'b0;
         env_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.filt_upd) begin
            filt_ff <= filt_in;
            prev_ff <= sample_ff;
            if (count_room) begin
               sum_ff   <= sum_in;
               count_ff <= count_ff + CNT_W'(1);
            end
         end
         // The block sum is handed to the divider and cleared in the same cycle.
         if (cmd.div_start && !cmd.div_level) begin
            sum_ff   <= '0;
            count_ff <= '0;
         end
         if (cmd.mul_en && (cmd.mul_sel == vlm_pkg::MUL_FLOOR)) begin
            floor_ff <= floor_base;
            known_ff <= 1'b1;
         end
         if (cmd.floor_upd) begin
            floor_ff <= floor_in;
         end
         if (cmd.env_upd) begin
            env_ff       <= env_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_sample;
         last_ff   <= req_block_end;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.mean_load) begin
         mean_ff <= quotient[31:0];
      end
      if (cmd.target_load) begin
         target_ff <= target_in;
      end
      if (cmd.env_upd) begin
         level_ff <= level_in;
      end
   end

   assign sts.last     = last_ff;
   assign sts.div_busy = div_busy;
   assign sts.out_full = rsp_valid_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = level_ff;

endmodule

`default_nettype wire

// File: rtl/core/vlm_ctrl.sv
// Controller state machine that sequences the voice level meter datapath.
`default_nettype none

module vlm_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire vlm_pkg::sts_type sts,
   output vlm_pkg::cmd_type      cmd
);

   vlm_pkg::state_type state_ff;
   vlm_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vlm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd         = '0;
      cmd.mul_sel = vlm_pkg::MUL_FILT;
      state_in    = state_ff;
      unique case (state_ff)
         vlm_pkg::ST_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = vlm_pkg::ST_MUL;
            end
         end
         vlm_pkg::ST_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = vlm_pkg::MUL_FILT;
            state_in    = vlm_pkg::ST_ACC;
         end
         vlm_pkg::ST_ACC: begin
            cmd.filt_upd = 1'b1;
            state_in     = sts.last ? vlm_pkg::ST_DIVM_GO : vlm_pkg::ST_IDLE;
         end
         vlm_pkg::ST_DIVM_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_level = 1'b0;
            state_in      = vlm_pkg::ST_DIVM_WAIT;
         end
         vlm_pkg::ST_DIVM_WAIT: begin
            if (!sts.div_busy) begin
               cmd.mean_load = 1'b1;
               state_in      = vlm_pkg::ST_FLR_MUL;
            end
         end
         vlm_pkg::ST_FLR_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = vlm_pkg::MUL_FLOOR;
            state_in    = vlm_pkg::ST_FLR_UPD;
         end
         vlm_pkg::ST_FLR_UPD: begin
            cmd.floor_upd = 1'b1;
            state_in      = vlm_pkg::ST_DIVL_GO;
         end
         vlm_pkg::ST_DIVL_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_level = 1'b1;
            state_in      = vlm_pkg::ST_DIVL_WAIT;
         end
         vlm_pkg::ST_DIVL_WAIT: begin
            if (!sts.div_busy) begin
               cmd.target_load = 1'b1;
               state_in        = vlm_pkg::ST_ENV_MUL;
            end
         end
         vlm_pkg::ST_ENV_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = vlm_pkg::MUL_ENV;
            state_in    = vlm_pkg::ST_ENV_UPD;
         end
         vlm_pkg::ST_ENV_UPD: begin
            // The envelope only advances once the previous level has been taken.
            if (!sts.out_full) begin
               cmd.env_upd = 1'b1;
               state_in    = vlm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vlm_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == vlm_pkg::ST_IDLE);

endmodule

`default_nettype wire

// File: rtl/core/vlm_checker.sv
// Port-level assertions for the voice level meter and their bind.
`default_nettype none

module vlm_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic req_block_end,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [vlm_pkg::LEVEL_W-1:0] rsp_level
);

   // A level that is not taken stays on the port unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_level)))
      else $error("rsp level dropped or changed while stalled");

   // Reset leaves no level pending and the block ready for a request.
   assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("state after reset is wrong");

   // Each request is processed over several cycles before another is taken.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted in back-to-back cycles");

   // A request that does not end a block never brings a new level.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_block_end) |=> !$rose(rsp_valid))
      else $error("level produced without a block end");

endmodule

bind voice_level_meter vlm_checker u_vlm_checker (.*);

`default_nettype wire
